// File: src/p2cl_pkg.sv
//------------------------------------------------------------------------------
// p2cl_pkg
// Shared field widths, command and status codes, controller states and the
// command/status structs of the point-to-cell link index.
//------------------------------------------------------------------------------
`default_nettype none

package p2cl_pkg;

    // Payload field widths.
    localparam int CMD_W    = 3;
    localparam int CELL_W   = 12;
    localparam int POINT_W  = 10;
    localparam int LINK_W   = 12;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 13;
    localparam int NP_W     = 11;

    // Configuration port.
    localparam int PADDR_W = 1;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_NUM_POINTS = 1'b0;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BUILD = 3'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_POINT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_Q0,
        S_Q1,
        S_Q2,
        S_R0,
        S_R1,
        S_ZERO,
        S_HIST_RD,
        S_HIST_PT,
        S_HIST_WR,
        S_PRE_RD,
        S_PRE_WR,
        S_SC_RD,
        S_SC_PT,
        S_SC_WR
    } ctrl_state_t;

    // Datapath operations, one per controller step.
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_DISPATCH,
        OP_Q0,
        OP_Q1,
        OP_Q2,
        OP_R0,
        OP_R1,
        OP_ZERO,
        OP_HIST_RD,
        OP_HIST_PT,
        OP_HIST_WR,
        OP_PRE_RD,
        OP_PRE_WR,
        OP_SC_RD,
        OP_SC_PT,
        OP_SC_WR,
        OP_RESP
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   in_ready;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_build;
        logic q_go;
        logic r_go;
        logic i_eq_np;
        logic i_eq_fill;
        logic p_ok;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: src/p2cl_if.sv
//------------------------------------------------------------------------------
// p2cl_if
// Valid/ready channels for request items and result items.
//------------------------------------------------------------------------------
`default_nettype none

interface p2cl_req_if;
    logic                        valid;
    logic                        ready;
    logic [p2cl_pkg::CMD_W-1:0]   command;
    logic [p2cl_pkg::CELL_W-1:0]  cell_id;
    logic [p2cl_pkg::POINT_W-1:0] node_id;
    logic [p2cl_pkg::LINK_W-1:0]  link_index;

    modport source (output valid, command, cell_id, node_id, link_index, input ready);
    modport sink (input valid, command, cell_id, node_id, link_index, output ready);
endinterface

interface p2cl_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [p2cl_pkg::STATUS_W-1:0] status;
    logic [p2cl_pkg::COUNT_W-1:0]  cells_for_point;
    logic [p2cl_pkg::COUNT_W-1:0]  first_link;
    logic [p2cl_pkg::CELL_W-1:0]   linked_cell;
    logic [p2cl_pkg::COUNT_W-1:0]  incidence_total;

    modport source (output valid, status, cells_for_point, first_link, linked_cell,
                    incidence_total, input ready);
    modport sink (input valid, status, cells_for_point, first_link, linked_cell,
                  incidence_total, output ready);
endinterface

`default_nettype wire

// File: src/point_to_cell_link_index.sv
//------------------------------------------------------------------------------
// point_to_cell_link_index
// Inverted point-to-cell index in compressed-row form, with an APB register
// for the active point count.
//------------------------------------------------------------------------------
//  Channel | Dir | Handshake         | Content
//  req     | in  | valid/ready       | command, cell_id, node_id, link_index
//  rsp     | out | valid/ready       | status, counts, first link, cell, total
//  apb     | in  | psel/penable      | num_points at address 0
//
//  One item at a time. Clear, add, unknown commands and rejected reads and
//  queries finish in dispatch; read and query then step through registered RAM reads.
//  Build runs a zeroing sweep, a histogram
//  and a scatter pass over the incidence RAM, and a prefix pass over offsets.
//  Reset clears the fill count, the built flag and the result valid; the
//  RAMs need no clearing. A stalled result holds the block before the next item.
//------------------------------------------------------------------------------
`default_nettype none

module point_to_cell_link_index #(
    parameter int MAX_POINTS     = 1024,
    parameter int MAX_INCIDENCES = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    p2cl_req_if.sink                            req,
    p2cl_rsp_if.source                          rsp,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [p2cl_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [p2cl_pkg::PDATA_W-1:0]   pwdata,
    output logic [p2cl_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    logic [p2cl_pkg::NP_W-1:0] num_points_reg;
    logic [p2cl_pkg::NP_W-1:0] num_points_next;
    logic                      cfg_wr;
    logic                      req_fire;
    p2cl_pkg::ctrl_cmd_t       cmd;
    p2cl_pkg::dp_stat_t        stat;

    // Register write and read-back.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == p2cl_pkg::ADDR_NUM_POINTS);
    assign num_points_next = cfg_wr ? pwdata[p2cl_pkg::NP_W-1:0] : num_points_reg;
    assign prdata = (paddr == p2cl_pkg::ADDR_NUM_POINTS) ?
                    p2cl_pkg::PDATA_W'(num_points_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg <= '0;
        end
        else
        begin
            num_points_reg <= num_points_next;
        end
    end

    p2cl_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .req_fire(req_fire),
        .stat(stat),
        .cmd(cmd)
    );

    p2cl_dp #(
        .MAX_POINTS(MAX_POINTS),
        .MAX_INCIDENCES(MAX_INCIDENCES)
    ) u_dp (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .num_points(num_points_reg),
        .cfg_clr(cfg_wr),
        .stat(stat),
        .req_fire(req_fire),
        .req(req),
        .rsp(rsp)
    );

endmodule

`default_nettype wire

// File: src/p2cl_ram.sv
//------------------------------------------------------------------------------
// p2cl_ram
// Generic single-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
`default_nettype none

module p2cl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                   clk,
    input  wire logic                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]       wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: src/p2cl_ctrl.sv
//------------------------------------------------------------------------------
// p2cl_ctrl
// Sequencer: walks each command through its datapath steps.
//------------------------------------------------------------------------------
`default_nettype none

module p2cl_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_fire,
    input  wire p2cl_pkg::dp_stat_t  stat,
    output p2cl_pkg::ctrl_cmd_t      cmd
);

    p2cl_pkg::ctrl_state_t state_reg;
    p2cl_pkg::ctrl_state_t state_next;
    logic                  resp_reg;
    logic                  resp_next;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= p2cl_pkg::S_IDLE;
            resp_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            resp_reg  <= resp_next;
        end
    end

    // Next state. The response step is kept as a flag held in idle state.
    always_comb
    begin
        state_next = state_reg;
        resp_next  = resp_reg;
        unique case (state_reg)
            p2cl_pkg::S_IDLE:
            begin
                if (resp_reg)
                begin
                    if (stat.out_free)
                    begin
                        resp_next = 1'b0;
                    end
                end
                else if (req_fire)
                begin
                    state_next = p2cl_pkg::S_DISPATCH;
                end
            end
            p2cl_pkg::S_DISPATCH:
            begin
                if (stat.is_build)
                begin
                    state_next = p2cl_pkg::S_ZERO;
                end
                else if (stat.q_go)
                begin
                    state_next = p2cl_pkg::S_Q0;
                end
                else if (stat.r_go)
                begin
                    state_next = p2cl_pkg::S_R0;
                end
                else
                begin
                    state_next = p2cl_pkg::S_IDLE;
                    resp_next  = 1'b1;
                end
            end
            p2cl_pkg::S_Q0: state_next = p2cl_pkg::S_Q1;
            p2cl_pkg::S_Q1: state_next = p2cl_pkg::S_Q2;
            p2cl_pkg::S_Q2:
            begin
                state_next = p2cl_pkg::S_IDLE;
                resp_next  = 1'b1;
            end
            p2cl_pkg::S_R0: state_next = p2cl_pkg::S_R1;
            p2cl_pkg::S_R1:
            begin
                state_next = p2cl_pkg::S_IDLE;
                resp_next  = 1'b1;
            end
            p2cl_pkg::S_ZERO:
            begin
                if (stat.i_eq_np)
                begin
                    state_next = p2cl_pkg::S_HIST_RD;
                end
            end
            p2cl_pkg::S_HIST_RD:
            begin
                state_next = stat.i_eq_fill ? p2cl_pkg::S_PRE_RD : p2cl_pkg::S_HIST_PT;
            end
            p2cl_pkg::S_HIST_PT:
            begin
                state_next = stat.p_ok ? p2cl_pkg::S_HIST_WR : p2cl_pkg::S_HIST_RD;
            end
            p2cl_pkg::S_HIST_WR: state_next = p2cl_pkg::S_HIST_RD;
            p2cl_pkg::S_PRE_RD:  state_next = p2cl_pkg::S_PRE_WR;
            p2cl_pkg::S_PRE_WR:
            begin
                state_next = stat.i_eq_np ? p2cl_pkg::S_SC_RD : p2cl_pkg::S_PRE_RD;
            end
            p2cl_pkg::S_SC_RD:
            begin
                if (stat.i_eq_fill)
                begin
                    state_next = p2cl_pkg::S_IDLE;
                    resp_next  = 1'b1;
                end
                else
                begin
                    state_next = p2cl_pkg::S_SC_PT;
                end
            end
            p2cl_pkg::S_SC_PT:
            begin
                state_next = stat.p_ok ? p2cl_pkg::S_SC_WR : p2cl_pkg::S_SC_RD;
            end
            p2cl_pkg::S_SC_WR: state_next = p2cl_pkg::S_SC_RD;
            default: state_next = p2cl_pkg::S_IDLE;
        endcase
    end

    // Outputs: one datapath operation per state.
    always_comb
    begin
        cmd.in_ready = 1'b0;
        unique case (state_reg)
            p2cl_pkg::S_IDLE:
            begin
                cmd.op       = resp_reg ? p2cl_pkg::OP_RESP : p2cl_pkg::OP_IDLE;
                cmd.in_ready = !resp_reg;
            end
            p2cl_pkg::S_DISPATCH: cmd.op = p2cl_pkg::OP_DISPATCH;
            p2cl_pkg::S_Q0:       cmd.op = p2cl_pkg::OP_Q0;
            p2cl_pkg::S_Q1:       cmd.op = p2cl_pkg::OP_Q1;
            p2cl_pkg::S_Q2:       cmd.op = p2cl_pkg::OP_Q2;
            p2cl_pkg::S_R0:       cmd.op = p2cl_pkg::OP_R0;
            p2cl_pkg::S_R1:       cmd.op = p2cl_pkg::OP_R1;
            p2cl_pkg::S_ZERO:     cmd.op = p2cl_pkg::OP_ZERO;
            p2cl_pkg::S_HIST_RD:  cmd.op = p2cl_pkg::OP_HIST_RD;
            p2cl_pkg::S_HIST_PT:  cmd.op = p2cl_pkg::OP_HIST_PT;
            p2cl_pkg::S_HIST_WR:  cmd.op = p2cl_pkg::OP_HIST_WR;
            p2cl_pkg::S_PRE_RD:   cmd.op = p2cl_pkg::OP_PRE_RD;
            p2cl_pkg::S_PRE_WR:   cmd.op = p2cl_pkg::OP_PRE_WR;
            p2cl_pkg::S_SC_RD:    cmd.op = p2cl_pkg::OP_SC_RD;
            p2cl_pkg::S_SC_PT:    cmd.op = p2cl_pkg::OP_SC_PT;
            p2cl_pkg::S_SC_WR:    cmd.op = p2cl_pkg::OP_SC_WR;
            default:              cmd.op = p2cl_pkg::OP_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// File: src/p2cl_dp.sv
//------------------------------------------------------------------------------
// p2cl_dp
// Datapath: incidence list, offset and cursor tables, link table, counters
// and the result register.
//------------------------------------------------------------------------------
`default_nettype none

module p2cl_dp #(
    parameter int MAX_POINTS     = 1024,
    parameter int MAX_INCIDENCES = 4096
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire p2cl_pkg::ctrl_cmd_t           cmd,
    input  wire logic [p2cl_pkg::NP_W-1:0]     num_points,
    input  wire logic                          cfg_clr,
    output p2cl_pkg::dp_stat_t                 stat,
    output logic                               req_fire,
    p2cl_req_if.sink                           req,
    p2cl_rsp_if.source                         rsp
);

    localparam int CW  = $clog2(MAX_INCIDENCES + 1);
    localparam int PW  = $clog2(MAX_POINTS + 1);
    localparam int NW  = (PW > p2cl_pkg::NP_W) ? PW : p2cl_pkg::NP_W;
    localparam int XW  = ((CW > NW) ? CW : NW) + 1;
    localparam int IAW = (MAX_INCIDENCES > 1) ? $clog2(MAX_INCIDENCES) : 1;
    localparam int OAW = $clog2(MAX_POINTS + 1);
    localparam int CAW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int IW  = p2cl_pkg::POINT_W + p2cl_pkg::CELL_W;

    // Item registers.
    logic [p2cl_pkg::CMD_W-1:0]   cmd_reg, cmd_next;
    logic [p2cl_pkg::CELL_W-1:0]  cell_reg, cell_next;
    logic [p2cl_pkg::POINT_W-1:0] pt_reg, pt_next;
    logic [p2cl_pkg::LINK_W-1:0]  idx_reg, idx_next;

    // Index state and walk registers.
    logic [CW-1:0]                fill_reg, fill_next;
    logic                         built_reg, built_next;
    logic [CW-1:0]                total_reg, total_next;
    logic [XW-1:0]                i_reg, i_next;
    logic [CW-1:0]                acc_reg, acc_next;
    logic [p2cl_pkg::POINT_W-1:0] p_reg, p_next;
    logic [p2cl_pkg::CELL_W-1:0]  c_reg, c_next;

    // Result fields and output register.
    logic [p2cl_pkg::STATUS_W-1:0] st_reg, st_next;
    logic [CW-1:0]                 first_reg, first_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [p2cl_pkg::CELL_W-1:0]   lk_reg, lk_next;
    logic                          ov_reg, ov_next;
    logic [p2cl_pkg::STATUS_W-1:0] o_st_reg, o_st_next;
    logic [p2cl_pkg::COUNT_W-1:0]  o_cnt_reg, o_cnt_next;
    logic [p2cl_pkg::COUNT_W-1:0]  o_first_reg, o_first_next;
    logic [p2cl_pkg::CELL_W-1:0]   o_lk_reg, o_lk_next;
    logic [p2cl_pkg::COUNT_W-1:0]  o_tot_reg, o_tot_next;

    // Memory ports.
    logic           inc_we;
    logic [IAW-1:0] inc_waddr, inc_raddr;
    logic [IW-1:0]  inc_wdata, inc_rdata;
    logic           off_we;
    logic [OAW-1:0] off_waddr, off_raddr;
    logic [CW-1:0]  off_wdata, off_rdata;
    logic           cur_we;
    logic [CAW-1:0] cur_waddr, cur_raddr;
    logic [CW-1:0]  cur_wdata, cur_rdata;
    logic           lk_we;
    logic [IAW-1:0] lk_waddr, lk_raddr;
    logic [p2cl_pkg::CELL_W-1:0] lk_wdata, lk_rdata;

    // Derived values.
    logic [XW-1:0]                np_x, np_act, pt_x, idx_x;
    logic [p2cl_pkg::POINT_W-1:0] inc_p;
    logic [p2cl_pkg::CELL_W-1:0]  inc_c;
    logic                         pt_bad, full, rd_bad, out_free;
    logic [CW-1:0]                sum;

    p2cl_ram #(.WIDTH(IW), .DEPTH(MAX_INCIDENCES)) u_inc (
        .clk(clk), .we(inc_we), .waddr(inc_waddr), .wdata(inc_wdata),
        .raddr(inc_raddr), .rdata(inc_rdata)
    );

    p2cl_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS + 1)) u_off (
        .clk(clk), .we(off_we), .waddr(off_waddr), .wdata(off_wdata),
        .raddr(off_raddr), .rdata(off_rdata)
    );

    p2cl_ram #(.WIDTH(CW), .DEPTH(MAX_POINTS)) u_cur (
        .clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
        .raddr(cur_raddr), .rdata(cur_rdata)
    );

    p2cl_ram #(.WIDTH(p2cl_pkg::CELL_W), .DEPTH(MAX_INCIDENCES)) u_link (
        .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
        .raddr(lk_raddr), .rdata(lk_rdata)
    );

    // Active point count, range checks and status to the controller.
    always_comb
    begin
        np_x   = XW'(num_points);
        np_act = (np_x < XW'(MAX_POINTS)) ? np_x : XW'(MAX_POINTS);
        pt_x   = XW'(pt_reg);
        idx_x  = XW'(idx_reg);
        inc_p  = inc_rdata[IW-1:p2cl_pkg::CELL_W];
        inc_c  = inc_rdata[p2cl_pkg::CELL_W-1:0];
        pt_bad = pt_x >= np_act;
        full   = XW'(fill_reg) >= XW'(MAX_INCIDENCES);
        rd_bad = !built_reg || (idx_x >= XW'(total_reg)) || (idx_x >= XW'(MAX_INCIDENCES));
        out_free = !ov_reg || rsp.ready;
        sum    = acc_reg + off_rdata;

        stat.is_build  = cmd_reg == p2cl_pkg::CMD_BUILD;
        stat.q_go      = (cmd_reg == p2cl_pkg::CMD_QUERY) && !pt_bad && built_reg;
        stat.r_go      = (cmd_reg == p2cl_pkg::CMD_READ) && !rd_bad;
        stat.i_eq_np   = i_reg == np_act;
        stat.i_eq_fill = i_reg == XW'(fill_reg);
        stat.p_ok      = XW'(inc_p) < np_act;
        stat.out_free  = out_free;
    end

    assign req.ready = cmd.in_ready;
    assign req_fire  = req.valid && cmd.in_ready;

    // Step logic.
    always_comb
    begin
        cmd_next   = cmd_reg;
        cell_next  = cell_reg;
        pt_next    = pt_reg;
        idx_next   = idx_reg;
        fill_next  = fill_reg;
        built_next = built_reg;
        total_next = total_reg;
        i_next     = i_reg;
        acc_next   = acc_reg;
        p_next     = p_reg;
        c_next     = c_reg;
        st_next    = st_reg;
        first_next = first_reg;
        cnt_next   = cnt_reg;
        lk_next    = lk_reg;
        o_st_next    = o_st_reg;
        o_cnt_next   = o_cnt_reg;
        o_first_next = o_first_reg;
        o_lk_next    = o_lk_reg;
        o_tot_next   = o_tot_reg;
        ov_next      = ov_reg && !rsp.ready;

        inc_we    = 1'b0;
        inc_waddr = IAW'(fill_reg);
        inc_wdata = {pt_reg, cell_reg};
        inc_raddr = IAW'(i_reg);
        off_we    = 1'b0;
        off_waddr = OAW'(i_reg);
        off_wdata = '0;
        off_raddr = OAW'(i_reg);
        cur_we    = 1'b0;
        cur_waddr = CAW'(i_reg);
        cur_wdata = sum;
        cur_raddr = CAW'(inc_p);
        lk_we     = 1'b0;
        lk_waddr  = IAW'(cur_rdata);
        lk_wdata  = c_reg;
        lk_raddr  = IAW'(idx_reg);

        case (cmd.op)
            p2cl_pkg::OP_IDLE:
            begin
                if (req_fire)
                begin
                    cmd_next  = req.command;
                    cell_next = req.cell_id;
                    pt_next   = req.node_id;
                    idx_next  = req.link_index;
                end
            end
            p2cl_pkg::OP_DISPATCH:
            begin
                st_next    = p2cl_pkg::ST_OK;
                first_next = '0;
                cnt_next   = '0;
                lk_next    = '0;
                i_next     = '0;
                acc_next   = '0;
                case (cmd_reg)
                    p2cl_pkg::CMD_CLEAR:
                    begin
                        fill_next  = '0;
                        built_next = 1'b0;
                    end
                    p2cl_pkg::CMD_ADD:
                    begin
                        if (pt_bad)
                        begin
                            st_next = p2cl_pkg::ST_BAD_POINT;
                        end
                        else if (full)
                        begin
                            st_next = p2cl_pkg::ST_FULL;
                        end
                        else
                        begin
                            inc_we     = 1'b1;
                            fill_next  = fill_reg + 1'b1;
                            built_next = 1'b0;
                        end
                    end
                    p2cl_pkg::CMD_QUERY:
                    begin
                        if (pt_bad)
                        begin
                            st_next = p2cl_pkg::ST_BAD_POINT;
                        end
                    end
                    p2cl_pkg::CMD_READ:
                    begin
                        if (rd_bad)
                        begin
                            st_next = p2cl_pkg::ST_BAD_INDEX;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            p2cl_pkg::OP_Q0:
            begin
                off_raddr = OAW'(pt_x);
            end
            p2cl_pkg::OP_Q1:
            begin
                first_next = off_rdata;
                off_raddr  = OAW'(pt_x + 1'b1);
            end
            p2cl_pkg::OP_Q2:
            begin
                cnt_next = off_rdata - first_reg;
            end
            p2cl_pkg::OP_R0:
            begin
                lk_raddr = IAW'(idx_reg);
            end
            p2cl_pkg::OP_R1:
            begin
                lk_next = lk_rdata;
            end
            // Clear offsets 0..np before counting.
            p2cl_pkg::OP_ZERO:
            begin
                off_we = 1'b1;
                i_next = stat.i_eq_np ? '0 : i_reg + 1'b1;
            end
            // Histogram: count each point's incidences into offset p+1.
            p2cl_pkg::OP_HIST_RD:
            begin
                if (stat.i_eq_fill)
                begin
                    i_next = '0;
                end
            end
            p2cl_pkg::OP_HIST_PT:
            begin
                p_next    = inc_p;
                off_raddr = OAW'(XW'(inc_p) + 1'b1);
                if (!stat.p_ok)
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            p2cl_pkg::OP_HIST_WR:
            begin
                off_we    = 1'b1;
                off_waddr = OAW'(XW'(p_reg) + 1'b1);
                off_wdata = off_rdata + 1'b1;
                i_next    = i_reg + 1'b1;
            end
            p2cl_pkg::OP_PRE_RD:
            begin
                off_raddr = OAW'(i_reg);
            end
            // Running sum; offsets and cursors take the same value.
            p2cl_pkg::OP_PRE_WR:
            begin
                off_we    = 1'b1;
                off_wdata = sum;
                acc_next  = sum;
                cur_we    = i_reg < np_act;
                if (stat.i_eq_np)
                begin
                    total_next = sum;
                    i_next     = '0;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            p2cl_pkg::OP_SC_RD:
            begin
                if (stat.i_eq_fill)
                begin
                    built_next = 1'b1;
                end
            end
            p2cl_pkg::OP_SC_PT:
            begin
                p_next    = inc_p;
                c_next    = inc_c;
                cur_raddr = CAW'(inc_p);
                if (!stat.p_ok)
                begin
                    i_next = i_reg + 1'b1;
                end
            end
            // Scatter the cell id through the point's cursor.
            p2cl_pkg::OP_SC_WR:
            begin
                lk_we     = XW'(cur_rdata) < XW'(MAX_INCIDENCES);
                cur_we    = 1'b1;
                cur_waddr = CAW'(p_reg);
                cur_wdata = cur_rdata + 1'b1;
                i_next    = i_reg + 1'b1;
            end
            p2cl_pkg::OP_RESP:
            begin
                if (out_free)
                begin
                    ov_next      = 1'b1;
                    o_st_next    = st_reg;
                    o_cnt_next   = p2cl_pkg::COUNT_W'(cnt_reg);
                    o_first_next = p2cl_pkg::COUNT_W'(first_reg);
                    o_lk_next    = lk_reg;
                    o_tot_next   = p2cl_pkg::COUNT_W'(fill_reg);
                end
            end
            default:
            begin
            end
        endcase

        // A point count write invalidates the index.
        if (cfg_clr)
        begin
            built_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            built_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            fill_reg  <= fill_next;
            built_reg <= built_next;
            ov_reg    <= ov_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        cell_reg    <= cell_next;
        pt_reg      <= pt_next;
        idx_reg     <= idx_next;
        total_reg   <= total_next;
        i_reg       <= i_next;
        acc_reg     <= acc_next;
        p_reg       <= p_next;
        c_reg       <= c_next;
        st_reg      <= st_next;
        first_reg   <= first_next;
        cnt_reg     <= cnt_next;
        lk_reg      <= lk_next;
        o_st_reg    <= o_st_next;
        o_cnt_reg   <= o_cnt_next;
        o_first_reg <= o_first_next;
        o_lk_reg    <= o_lk_next;
        o_tot_reg   <= o_tot_next;
    end

    assign rsp.valid           = ov_reg;
    assign rsp.status          = o_st_reg;
    assign rsp.cells_for_point = o_cnt_reg;
    assign rsp.first_link      = o_first_reg;
    assign rsp.linked_cell     = o_lk_reg;
    assign rsp.incidence_total = o_tot_reg;

endmodule

`default_nettype wire
